FILE: src/artdmx_pkg.sv
package artdmx_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CHAN_W    = 10;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned OPCODE_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [OPCODE_W-1:0] OPC_POLL   = 16'h2000;
    localparam logic [OPCODE_W-1:0] OPC_OUTPUT = 16'h5000;

    // Byte offsets of the fields in the Art-Net header.
    localparam logic [POS_W-1:0] POS_IDENT_END = 10'd8;
    localparam logic [POS_W-1:0] POS_OPC_LO    = 10'd8;
    localparam logic [POS_W-1:0] POS_OPC_HI    = 10'd9;
    localparam logic [POS_W-1:0] POS_UNIVERSE  = 10'd14;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 10'd16;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 10'd17;
    localparam logic [POS_W-1:0] POS_DATA      = 10'd18;
    localparam logic [POS_W-1:0] POS_MAX       = 10'd1023;

    // Channel number of a data byte is its offset minus this.
    localparam logic [POS_W-1:0] CHAN_OFFSET   = 10'd17;
    localparam logic [CHAN_W-1:0] COUNT_SAT    = 10'd1023;
    localparam logic [BYTE_W-1:0] LEN_HI_SAT   = 8'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE = 2'd1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_POLL  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAN_W-1:0]   channel;
        logic [BYTE_W-1:0]   level;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    function automatic logic [BYTE_W-1:0] ident_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0: b = 8'h41; // A
            3'd1: b = 8'h72; // r
            3'd2: b = 8'h74; // t
            3'd3: b = 8'h2D; // -
            3'd4: b = 8'h4E; // N
            3'd5: b = 8'h65; // e
            3'd6: b = 8'h74; // t
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/artdmx_if.sv
interface artdmx_byte_if;
    logic                           valid;
    logic                           ready;
    logic [artdmx_pkg::BYTE_W-1:0]  packet_byte;
    logic                           last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface artdmx_result_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [artdmx_pkg::CHAN_W-1:0]  channel;
    logic [artdmx_pkg::BYTE_W-1:0]  level;

    modport source (output valid, output kind, output channel, output level, input ready);
    modport sink   (input valid, input kind, input channel, input level, output ready);
endinterface

FILE: src/artdmx_front.sv
module artdmx_front #(
    parameter int unsigned CHANNEL_LIMIT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [artdmx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [artdmx_pkg::NIBBLE_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  logic [artdmx_pkg::BYTE_W-1:0]       i_packet_byte,
    input  logic                                i_last_byte,
    output artdmx_pkg::t_push                   o_push
);

    localparam logic [artdmx_pkg::CHAN_W:0] LIMIT = (artdmx_pkg::CHAN_W + 1)'(CHANNEL_LIMIT);

    logic [artdmx_pkg::NIBBLE_W-1:0] r_subnet,   n_subnet;
    logic [artdmx_pkg::NIBBLE_W-1:0] r_universe, n_universe;
    logic [artdmx_pkg::POS_W-1:0]    r_pos,      n_pos;
    logic                            r_hdr_good, n_hdr_good;
    logic [artdmx_pkg::OPCODE_W-1:0] r_opcode,   n_opcode;
    logic                            r_uni_hit,  n_uni_hit;
    logic [artdmx_pkg::CHAN_W-1:0]   r_count,    n_count;

    logic [artdmx_pkg::CHAN_W:0]     full_count;
    logic [artdmx_pkg::POS_W-1:0]    chan_num;
    artdmx_pkg::t_push               push;

    assign full_count = {1'b0, r_count} + (artdmx_pkg::CHAN_W + 1)'(i_packet_byte);
    assign chan_num   = r_pos - artdmx_pkg::CHAN_OFFSET;

    always_comb begin
        n_subnet   = r_subnet;
        n_universe = r_universe;
        n_pos      = r_pos;
        n_hdr_good = r_hdr_good;
        n_opcode   = r_opcode;
        n_uni_hit  = r_uni_hit;
        n_count    = r_count;
        push       = '{push: 1'b0,
                       cmd: '{kind: artdmx_pkg::KIND_WRITE, channel: '0, level: '0}};

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                artdmx_pkg::CFG_SUBNET:   n_subnet   = i_cfg_data;
                artdmx_pkg::CFG_UNIVERSE: n_universe = i_cfg_data;
                default: ;
            endcase
        end

        if (i_accept) begin
            if (r_pos < artdmx_pkg::POS_IDENT_END) begin
                if (i_packet_byte != artdmx_pkg::ident_byte(r_pos[2:0])) begin
                    n_hdr_good = 1'b0;
                end
            end else if (r_pos == artdmx_pkg::POS_OPC_LO) begin
                n_opcode = {8'h00, i_packet_byte};
            end else if (r_pos == artdmx_pkg::POS_OPC_HI) begin
                n_opcode = {i_packet_byte, r_opcode[7:0]};
                if (r_hdr_good && n_opcode == artdmx_pkg::OPC_POLL) begin
                    push.push     = 1'b1;
                    push.cmd.kind = artdmx_pkg::KIND_POLL;
                end
            end else if (r_pos == artdmx_pkg::POS_UNIVERSE) begin
                n_uni_hit = (i_packet_byte == {r_subnet, r_universe});
            end else if (r_pos == artdmx_pkg::POS_LEN_HI) begin
                n_count = (i_packet_byte >= artdmx_pkg::LEN_HI_SAT) ? artdmx_pkg::COUNT_SAT
                                                                    : {i_packet_byte[1:0], 8'h00};
            end else if (r_pos == artdmx_pkg::POS_LEN_LO) begin
                // A saturated high byte means the count is far above any limit.
                if (r_count == artdmx_pkg::COUNT_SAT || full_count > LIMIT) begin
                    n_count = LIMIT[artdmx_pkg::CHAN_W-1:0];
                end else begin
                    n_count = full_count[artdmx_pkg::CHAN_W-1:0];
                end
            end else if (r_pos >= artdmx_pkg::POS_DATA) begin
                if (r_hdr_good && r_opcode == artdmx_pkg::OPC_OUTPUT && r_uni_hit &&
                    chan_num <= r_count) begin
                    push.push        = 1'b1;
                    push.cmd.kind    = artdmx_pkg::KIND_WRITE;
                    push.cmd.channel = chan_num;
                    push.cmd.level   = i_packet_byte;
                end
            end

            if (i_last_byte) begin
                n_pos      = '0;
                n_hdr_good = 1'b1;
                n_opcode   = '0;
                n_uni_hit  = 1'b0;
                n_count    = '0;
            end else if (r_pos < artdmx_pkg::POS_MAX) begin
                n_pos = r_pos + artdmx_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subnet   <= '0;
            r_universe <= '0;
            r_pos      <= '0;
            r_hdr_good <= 1'b1;
            r_opcode   <= '0;
            r_uni_hit  <= 1'b0;
            r_count    <= '0;
        end else begin
            r_subnet   <= n_subnet;
            r_universe <= n_universe;
            r_pos      <= n_pos;
            r_hdr_good <= n_hdr_good;
            r_opcode   <= n_opcode;
            r_uni_hit  <= n_uni_hit;
            r_count    <= n_count;
        end
    end

    assign o_push = push;

endmodule

FILE: src/artdmx_queue.sv
module artdmx_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  artdmx_pkg::t_push   i_push,
    output logic                o_full,
    output logic                o_valid,
    output artdmx_pkg::t_cmd    o_cmd,
    input  logic                i_pop
);

    artdmx_pkg::t_cmd                   r_mem [artdmx_pkg::QUEUE_DEPTH];
    logic [artdmx_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [artdmx_pkg::QCNT_W-1:0]      r_count;
    logic                               do_push, do_pop;

    assign o_full  = (r_count == artdmx_pkg::QCNT_W'(artdmx_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + artdmx_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + artdmx_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + artdmx_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - artdmx_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

FILE: src/artdmx_back.sv
module artdmx_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  artdmx_pkg::t_cmd        i_cmd,
    output logic                    o_pop,
    artdmx_result_if.source         o_result
);

    logic               r_valid;
    artdmx_pkg::t_cmd   r_res;
    logic               load;

    // The output register refills whenever it is empty or being drained.
    assign load  = i_valid && (!r_valid || o_result.ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res.kind <= i_cmd.kind;
            if (i_cmd.kind == artdmx_pkg::KIND_POLL) begin
                r_res.channel <= '0;
                r_res.level   <= '0;
            end else begin
                r_res.channel <= i_cmd.channel;
                r_res.level   <= i_cmd.level;
            end
        end
    end

    assign o_result.valid   = r_valid;
    assign o_result.kind    = r_res.kind;
    assign o_result.channel = r_res.channel;
    assign o_result.level   = r_res.level;

endmodule

FILE: src/artdmx_packet_receiver_unit.sv
// Art-Net receiver for ArtDmx and ArtPoll packets. The block takes a UDP payload one byte per
// transaction, with last_byte marking the final byte, checks the "Art-Net" identifier and the
// little-endian opcode, and produces at most one result transaction per byte: a poll-seen
// result (kind 1, channel and level zero) when an ArtPoll opcode completes, or a channel write
// (kind 0, channel 1 to N, level) for each data byte of an ArtDmx packet addressed to the
// configured subnet and universe. N is the length field clamped to CHANNEL_LIMIT, and writes
// also stop at the end of the packet. One byte is accepted in every clock cycle while the queue
// has room; the parser needs only a position counter compare and a field capture per byte.
// Results pass through a four-entry queue into an output register, so the input stalls only
// once that queue has filled behind a stalled output. Subnet and universe are to be written
// through the configuration port only while the block is idle, which the block itself does
// not enforce; register 0 is the subnet nibble, register 1 the universe nibble, and other
// indices are ignored.
module artnet_dmx_packet_receiver_unit #(
    parameter int unsigned CHANNEL_LIMIT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [artdmx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [artdmx_pkg::NIBBLE_W-1:0]     i_cfg_data,
    artdmx_byte_if.sink                         i_byte,
    artdmx_result_if.source                     o_result
);

    artdmx_pkg::t_push  push;
    artdmx_pkg::t_cmd   q_cmd;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               accept;

    // The front end takes a byte whenever the queue has room, so a byte that yields a
    // result never finds the queue full.
    assign i_byte.ready = !q_full;
    assign accept       = i_byte.valid && !q_full;

    artdmx_front #(
        .CHANNEL_LIMIT (CHANNEL_LIMIT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_packet_byte (i_byte.packet_byte),
        .i_last_byte   (i_byte.last_byte),
        .o_push        (push)
    );

    // The queue decouples parsing from delivery, so each side can stall on its own.
    artdmx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    artdmx_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

endmodule

FILE: dv/artnet_dmx_packet_receiver_unit_tb.sv
// Testbench for the Art-Net receiver. A predictor in this module tracks the header parser
// byte by byte and queues the channel writes and poll results that each accepted byte should
// cause. A scoreboard process compares every result transaction, field by field, with the
// oldest queued command.
module artnet_dmx_packet_receiver_unit_tb;
    import artdmx_pkg::*;

    localparam int unsigned CHAN_LIMIT   = 512;
    localparam int unsigned RESET_CYCLES = 8;
    // Drain time after the last expected result; it covers bytes that are still in the parser but
    // cause nothing.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned FINAL_WAIT   = 50_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 480;
    localparam int unsigned SWEEP_STEPS  = 6;
    localparam int unsigned PRESSURE_LEN = 64;

    // Register indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [BYTE_W-1:0] ART_ID [8] = '{
        8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
    };

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [NIBBLE_W-1:0]    cfg_data  = '0;

    artdmx_byte_if   byte_ch ();
    artdmx_result_if result_ch ();

    artnet_dmx_packet_receiver_unit #(
        .CHANNEL_LIMIT(CHAN_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_byte      (byte_ch),
        .o_result    (result_ch)
    );

    always #6 i_clk = ~i_clk;

    // Predictor copy of the configuration and of the per-packet parser state.
    logic [NIBBLE_W-1:0]    m_subnet;
    logic [NIBBLE_W-1:0]    m_universe;
    logic [POS_W-1:0]       m_pos;
    logic                   m_header_ok;
    logic [OPCODE_W-1:0]    m_opcode;
    logic                   m_uni_hit;
    int unsigned            m_count;

    t_cmd                   expected_cmds [$];
    logic [BYTE_W-1:0]      pkt_bytes [$];

    int unsigned            errors        = 0;
    int unsigned            cycles        = 0;
    int unsigned            bytes_sent    = 0;
    int unsigned            hold_requests = 0;
    bit                     gaps_on       = 1'b1;

    function automatic void restart_packet();
        m_pos       = '0;
        m_header_ok = 1'b1;
        m_opcode    = '0;
        m_uni_hit   = 1'b0;
        m_count     = 0;
    endfunction

    // Works out what one accepted byte causes and queues the resulting command, if any.
    function automatic void parse_artnet_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_cmd        cmd;
        bit          hit;
        int unsigned ch;
        int unsigned full;
        hit = 1'b0;
        cmd = '{kind: KIND_WRITE, channel: '0, level: '0};
        if (m_pos < POS_IDENT_END) begin
            if (b != ART_ID[m_pos[2:0]]) begin
                m_header_ok = 1'b0;
            end
        end else if (m_pos == POS_OPC_LO) begin
            m_opcode = {8'h00, b};
        end else if (m_pos == POS_OPC_HI) begin
            m_opcode = {b, m_opcode[7:0]};
            if (m_header_ok && m_opcode == OPC_POLL) begin
                cmd.kind = KIND_POLL;
                hit      = 1'b1;
            end
        end else if (m_pos == POS_UNIVERSE) begin
            m_uni_hit = (b == {m_subnet, m_universe});
        end else if (m_pos == POS_LEN_HI) begin
            if (b >= LEN_HI_SAT) begin
                m_count = 32'(COUNT_SAT);
            end else begin
                m_count = 32'(b) << 8;
            end
        end else if (m_pos == POS_LEN_LO) begin
            full    = (m_count == 32'(COUNT_SAT)) ? 32'h1_0000 : m_count + 32'(b);
            m_count = (full > CHAN_LIMIT) ? CHAN_LIMIT : full;
        end else if (m_pos >= POS_DATA) begin
            ch = 32'(m_pos) - 32'(CHAN_OFFSET);
            if (m_header_ok && m_opcode == OPC_OUTPUT && m_uni_hit && ch <= m_count) begin
                cmd.channel = ch[CHAN_W-1:0];
                cmd.level   = b;
                hit         = 1'b1;
            end
        end
        if (hit) begin
            expected_cmds.push_back(cmd);
        end
        if (last) begin
            restart_packet();
        end else if (m_pos != POS_MAX) begin
            m_pos = m_pos + POS_W'(1);
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Scoreboard: updates the predictor on register writes and byte transactions, then checks
    // each result transaction against the oldest queued command.
    always @(posedge i_clk) begin : scoreboard
        t_cmd want;
        if (i_rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SUBNET:   m_subnet   = cfg_data;
                    CFG_UNIVERSE: m_universe = cfg_data;
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                parse_artnet_byte(byte_ch.packet_byte, byte_ch.last_byte);
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected result: kind %0d, channel %0d, level %0d",
                           result_ch.kind, result_ch.channel, result_ch.level);
                    errors++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (result_ch.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, result_ch.kind);
                        errors++;
                    end
                    if (result_ch.channel !== want.channel) begin
                        $error("channel: expected %0d, actual %0d",
                               want.channel, result_ch.channel);
                        errors++;
                    end
                    if (result_ch.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, result_ch.level);
                        errors++;
                    end
                end
            end
        end
    end

    // Result sink. Random stalls, plus a long hold-off whenever the test asks for one, so
    // that the output queue fills and the block has to stall its byte input.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned holds_seen;
        stall_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("artnet_dmx_packet_receiver_unit regression: fail");
        $finish;
    end

    // Offers one byte after a random gap and returns once the transaction has taken place.
    // Valid stays high into the next byte when there is no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.packet_byte <= b;
        byte_ch.last_byte   <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic transmit_packet();
        foreach (pkt_bytes[i]) begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
        pkt_bytes.delete();
    endtask

    // Drops valid and waits until every queued command has come out and the parser is empty.
    task automatic settle();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NIBBLE_W-1:0] val);
        settle();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Appends an 18-byte header; the version, sequence, physical and net bytes are random.
    function automatic void add_header(input logic [OPCODE_W-1:0] opcode,
                                       input logic [BYTE_W-1:0] uni,
                                       input logic [BYTE_W-1:0] len_hi,
                                       input logic [BYTE_W-1:0] len_lo);
        for (int i = 0; i < 8; i++) begin
            pkt_bytes.push_back(ART_ID[i]);
        end
        pkt_bytes.push_back(opcode[7:0]);
        pkt_bytes.push_back(opcode[15:8]);
        for (int i = 0; i < 4; i++) begin
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        pkt_bytes.push_back(uni);
        pkt_bytes.push_back(8'($urandom_range(0, 255)));
        pkt_bytes.push_back(len_hi);
        pkt_bytes.push_back(len_lo);
    endfunction

    function automatic void add_random(input int unsigned n);
        repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void trim_to(input int unsigned len);
        while (pkt_bytes.size() > len) begin
            void'(pkt_bytes.pop_back());
        end
    endfunction

    // One random packet. Most are well-formed ArtDmx or ArtPoll packets with random content;
    // the rest carry a wrong universe, a bad identifier, another opcode, an early end, or are
    // plain noise.
    task automatic send_random_packet();
        logic [BYTE_W-1:0]   uni_ok;
        logic [BYTE_W-1:0]   hi;
        logic [BYTE_W-1:0]   lo;
        logic [OPCODE_W-1:0] opcode;
        int unsigned         r;
        int unsigned         q;
        int unsigned         n;
        int unsigned         k;
        uni_ok = {m_subnet, m_universe};
        r = $urandom_range(0, 99);
        if (r < 45) begin
            q = $urandom_range(0, 9);
            if (q < 6) begin
                // Small count: data ends at the count, beyond it, or short of it.
                hi = 8'h00;
                lo = 8'($urandom_range(0, 24));
                case ($urandom_range(0, 2))
                    0:       n = 32'(lo);
                    1:       n = 32'(lo) + $urandom_range(1, 6);
                    default: n = (lo > 0) ? $urandom_range(0, 32'(lo) - 1) : 0;
                endcase
            end else if (q == 6) begin
                hi = 8'($urandom_range(1, 3));
                lo = 8'($urandom_range(0, 255));
                n  = $urandom_range(0, 30);
            end else if (q == 7) begin
                // A high length byte of four or more saturates the count.
                hi = 8'($urandom_range(4, 255));
                lo = 8'($urandom_range(0, 255));
                n  = $urandom_range(0, 30);
            end else begin
                hi = 8'h00;
                lo = 8'($urandom_range(25, 255));
                n  = $urandom_range(0, 40);
            end
            add_header(OPC_OUTPUT, uni_ok, hi, lo);
            add_random(n);
        end else if (r < 55) begin
            lo = 8'($urandom_range(0, 20));
            add_header(OPC_OUTPUT, uni_ok ^ (8'h01 << $urandom_range(0, 7)), 8'h00, lo);
            add_random(32'(lo));
        end else if (r < 65) begin
            add_header(OPC_POLL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            trim_to($urandom_range(10, 18));
            if ($urandom_range(0, 3) == 0) begin
                add_random($urandom_range(1, 8));
            end
        end else if (r < 73) begin
            // Bad identifier: one of the first eight bytes is corrupted.
            lo = 8'($urandom_range(0, 10));
            add_header($urandom_range(0, 1) ? OPC_POLL : OPC_OUTPUT, uni_ok, 8'h00, lo);
            add_random(32'(lo));
            k = $urandom_range(0, 7);
            pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(1, 255));
        end else if (r < 80) begin
            case ($urandom_range(0, 2))
                0:       opcode = OPC_OUTPUT ^ (16'h0001 << $urandom_range(0, 15));
                1:       opcode = OPC_POLL ^ (16'h0001 << $urandom_range(0, 15));
                default: opcode = 16'($urandom_range(0, 16'hFFFF));
            endcase
            if (opcode == OPC_POLL || opcode == OPC_OUTPUT) begin
                opcode[0] = ~opcode[0];
            end
            lo = 8'($urandom_range(0, 10));
            add_header(opcode, uni_ok, 8'h00, lo);
            add_random(32'(lo));
        end else if (r < 90) begin
            // Packet that ends inside the header.
            add_header($urandom_range(0, 1) ? OPC_POLL : OPC_OUTPUT, uni_ok, 8'h00,
                       8'($urandom_range(1, 10)));
            trim_to($urandom_range(1, 17));
        end else begin
            add_random($urandom_range(1, 30));
        end
        transmit_packet();
    endtask

    // A minimal poll packet, then a two-channel DMX packet carrying the lowest and highest
    // levels, both for the reset universe.
    task automatic test_directed_packets();
        add_header(OPC_POLL, 8'h00, 8'h00, 8'h00);
        trim_to(10);
        transmit_packet();
        add_header(OPC_OUTPUT, 8'h00, 8'h00, 8'h02);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        transmit_packet();
        settle();
    endtask

    // Random traffic under several subnet and universe settings, the extremes included. A write
    // to a spare index goes in each step and must leave the settings alone. One step runs
    // without any gaps on either side.
    task automatic test_config_sweep();
        logic [NIBBLE_W-1:0] sub;
        logic [NIBBLE_W-1:0] uni;
        int unsigned         target;
        for (int k = 0; k < SWEEP_STEPS; k++) begin
            case (k)
                0: begin
                    sub = 4'h0;
                    uni = 4'h0;
                end
                1: begin
                    sub = 4'hF;
                    uni = 4'hF;
                end
                2: begin
                    sub = 4'hA;
                    uni = 4'h5;
                end
                3: begin
                    sub = 4'h5;
                    uni = 4'hA;
                end
                default: begin
                    sub = 4'($urandom_range(0, 15));
                    uni = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_SUBNET, sub);
            write_reg(CFG_UNIVERSE, uni);
            write_reg(k[0] ? CFG_SPARE_A : CFG_SPARE_B, 4'($urandom_range(0, 15)));
            gaps_on = (k != 2);
            target  = bytes_sent + RANDOM_BYTES / SWEEP_STEPS;
            while (bytes_sent < target) begin
                send_random_packet();
            end
        end
        gaps_on = 1'b1;
        settle();
    endtask

    // A DMX packet sent back to back while the sink holds off for a long stretch, so the
    // result queue fills and the byte input has to stall.
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        @(posedge i_clk);
        hold_requests++;
        add_header(OPC_OUTPUT, {m_subnet, m_universe}, 8'h02, 8'h00);
        add_random(PRESSURE_LEN);
        transmit_packet();
        gaps_on = 1'b1;
        settle();
    endtask

    // A full 512-channel DMX packet that runs past the point where the byte position
    // saturates. The tail repeats a poll header, which a counter that wrapped would act upon.
    task automatic test_long_packet();
        add_header(OPC_OUTPUT, {m_subnet, m_universe}, 8'h02, 8'h00);
        add_random(32'(POS_MAX) + 1 - 32'(POS_DATA));
        add_header(OPC_POLL, {m_subnet, m_universe}, 8'h00, 8'h08);
        add_random(20);
        transmit_packet();
        settle();
    endtask

    initial begin : run
        int unsigned waited;
        byte_ch.valid       = 1'b0;
        byte_ch.packet_byte = '0;
        byte_ch.last_byte   = 1'b0;
        m_subnet            = '0;
        m_universe          = '0;
        restart_packet();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_packets();
        test_config_sweep();
        test_output_backpressure();
        test_long_packet();

        // Final drain, bounded so that missing results are reported rather than waited on.
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        waited = 0;
        while (expected_cmds.size() != 0 && waited < FINAL_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_cmds.size() != 0) begin
            $error("%0d expected results never arrived", expected_cmds.size());
            errors++;
        end

        if (errors == 0) begin
            $display("artnet_dmx_packet_receiver_unit regression: pass");
        end else begin
            $display("artnet_dmx_packet_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule
